/* rtl/tcp_ecf_pkg.sv */
// tcp_ecf_pkg: shared types and constants of the tcp echo connection block
// no dependencies; used by the connection cell and the top level
package tcp_ecf_pkg;

  localparam int unsigned CONN_ENTRIES = 8;
  localparam logic [10:0] MAX_PAYLOAD  = 11'd1460;

  localparam logic [7:0] F_FIN = 8'h01;
  localparam logic [7:0] F_SYN = 8'h02;
  localparam logic [7:0] F_RST = 8'h04;
  localparam logic [7:0] F_PSH = 8'h08;
  localparam logic [7:0] F_ACK = 8'h10;

  localparam logic [15:0] ECHO_PORT_RST = 16'd7;
  localparam logic [15:0] RWIN_RST      = 16'(8 * 1024);

  localparam logic [7:0] CFG_ECHO_PORT = 8'd0;
  localparam logic [7:0] CFG_RWIN      = 8'd1;

  typedef enum logic [1:0] {
    PH_SYNRCVD = 2'd0,
    PH_ESTAB   = 2'd1,
    PH_LASTACK = 2'd2
  } phase_t;

  // received segment header, length already clamped
  typedef struct packed {
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [7:0]  flags_in;
    logic [10:0] payload_len;
    logic [31:0] time_now;
  } seg_t;

  // outgoing header descriptor
  typedef struct packed {
    logic [7:0]  seg_flags;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [15:0] window_out;
    logic [15:0] local_port_out;
    logic [15:0] remote_port_out;
    logic [31:0] remote_addr_out;
    logic [10:0] echo_len;
  } res_t;

  // what the first matching cell reports, all zero from every other cell
  typedef struct packed {
    logic        hit;
    logic        fin_go;
    logic        psh_go;
    logic [31:0] snd;
    logic [31:0] rcv;
  } cell_view_t;

endpackage

/* rtl/tcp_ecf_if.sv */
// tcp_ecf_if: valid/ready channel interfaces for segments, results and config
// no dependencies
interface tcp_ecf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_in;
  logic [31:0] ack_in;
  logic [7:0]  flags_in;
  logic [10:0] payload_len;
  logic [31:0] time_now;
  modport source (output valid, src_addr, src_port, dst_port, seq_in, ack_in, flags_in,
                  payload_len, time_now, input ready);
  modport sink (input valid, src_addr, src_port, dst_port, seq_in, ack_in, flags_in,
                payload_len, time_now, output ready);
endinterface

interface tcp_ecf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_flags;
  logic [31:0] seq_out;
  logic [31:0] ack_out;
  logic [15:0] window_out;
  logic [15:0] local_port_out;
  logic [15:0] remote_port_out;
  logic [31:0] remote_addr_out;
  logic [10:0] echo_len;
  logic        last;
  modport source (output valid, seg_flags, seq_out, ack_out, window_out, local_port_out,
                  remote_port_out, remote_addr_out, echo_len, last, input ready);
  modport sink (input valid, seg_flags, seq_out, ack_out, window_out, local_port_out,
                remote_port_out, remote_addr_out, echo_len, last, output ready);
endinterface

interface tcp_ecf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tcp_ecf_cell.sv */
// tcp_ecf_cell: one connection entry with match, priority chain and update logic
// depends on tcp_ecf_pkg
module tcp_ecf_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcp_ecf_pkg::seg_t      seg,
  input  logic                   hit_in,
  input  logic                   free_in,
  input  logic                   apply,
  input  logic                   alloc_en,
  output logic                   hit_out,
  output logic                   free_out,
  output logic                   alloc_wr,
  output tcp_ecf_pkg::cell_view_t view
);

  logic                valid_r;
  tcp_ecf_pkg::phase_t phase_r;
  logic [31:0]         addr_r;
  logic [15:0]         rport_r;
  logic [15:0]         lport_r;
  logic [31:0]         rcv_r;
  logic [31:0]         snd_r;
  logic [31:0]         una_r;

  logic                match, my_hit, my_free, kill, fin_go, psh_go;
  tcp_ecf_pkg::phase_t ph1, ph2;
  logic [31:0]         snd1, una1, rcv2;

  always_comb begin
    match    = valid_r && addr_r == seg.src_addr && rport_r == seg.src_port &&
               lport_r == seg.dst_port;
    my_hit   = match && !hit_in;
    hit_out  = hit_in || match;
    my_free  = !valid_r && !free_in;
    free_out = free_in || !valid_r;
    alloc_wr = apply && alloc_en && my_free;

    ph1  = phase_r;
    snd1 = snd_r;
    una1 = una_r;
    kill = 1'b0;
    if ((seg.flags_in & tcp_ecf_pkg::F_ACK) != 8'h00) begin
      unique case (phase_r)
        tcp_ecf_pkg::PH_SYNRCVD: begin
          if (seg.ack_in == snd_r) begin
            una1 = snd_r;
            ph1  = tcp_ecf_pkg::PH_ESTAB;
          end
        end
        tcp_ecf_pkg::PH_ESTAB: begin
          una1 = seg.ack_in - 32'd1;
          snd1 = seg.ack_in;
        end
        tcp_ecf_pkg::PH_LASTACK: kill = 1'b1;
        default: ;
      endcase
    end
    // fin moves to last ack, so psh in the same segment is not served
    fin_go = !kill && (seg.flags_in & tcp_ecf_pkg::F_FIN) != 8'h00 &&
             ph1 == tcp_ecf_pkg::PH_ESTAB;
    psh_go = !kill && !fin_go && (seg.flags_in & tcp_ecf_pkg::F_PSH) != 8'h00 &&
             ph1 == tcp_ecf_pkg::PH_ESTAB;
    rcv2 = fin_go ? rcv_r + 32'd1 :
           psh_go ? rcv_r + {21'd0, seg.payload_len} : rcv_r;
    ph2  = fin_go ? tcp_ecf_pkg::PH_LASTACK : ph1;

    view = '0;
    if (my_hit) begin
      view.hit    = 1'b1;
      view.fin_go = fin_go;
      view.psh_go = psh_go;
      view.snd    = snd1;
      view.rcv    = rcv2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (apply && my_hit) begin
      valid_r <= !kill;
    end else if (alloc_wr) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (apply && my_hit) begin
      phase_r <= ph2;
      snd_r   <= snd1;
      una_r   <= una1;
      rcv_r   <= rcv2;
    end else if (alloc_wr) begin
      phase_r <= tcp_ecf_pkg::PH_SYNRCVD;
      addr_r  <= seg.src_addr;
      rport_r <= seg.src_port;
      lport_r <= seg.dst_port;
      rcv_r   <= seg.seq_in + 32'd1;
      snd_r   <= seg.time_now + 32'd1;
      una_r   <= seg.time_now;
    end
  end

endmodule

/* rtl/tcp_echo_connection_fsm.sv */
// tcp_echo_connection_fsm: header-level tcp echo responder over a row of connection cells
// depends on tcp_ecf_pkg, tcp_ecf_if and tcp_ecf_cell
//
//  channel | port    | dir | transaction
//  --------+---------+-----+------------------------------------------
//  segment | in_ch   | in  | one received segment header
//  result  | out_ch  | out | one outgoing header descriptor, last flag
//  config  | cfg_ch  | in  | register index and 16-bit write data
//
// a segment is accepted in idle, looked up and applied in the lookup state, and its zero
// to two results are sent from the output state; the cell chain lookup is combinational.
// a result waits in its register until out_ch.ready; no new segment is taken meanwhile.
// synchronous active-low reset empties the table and restores the register defaults.
// config writes are always taken.
module tcp_echo_connection_fsm (
  input logic         clk,
  input logic         rst_n,
  tcp_ecf_in_if.sink  in_ch,
  tcp_ecf_out_if.source out_ch,
  tcp_ecf_cfg_if.sink cfg_ch
);

  localparam int unsigned N = tcp_ecf_pkg::CONN_ENTRIES;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_OUT} state_t;

  state_t            state_r;
  tcp_ecf_pkg::seg_t seg_r;
  tcp_ecf_pkg::res_t res0_r, res1_r, res0_nxt, res1_nxt;
  logic              idx_r;
  logic              lastidx_r, lastidx_nxt;
  logic [1:0]        cnt_nxt;
  logic [15:0]       echo_port_r;
  logic [15:0]       rwin_r;
  logic              apply, alloc_en;

  logic [N:0]              hit_c, free_c;
  logic [N-1:0]            alloc_wr, hit_v;
  tcp_ecf_pkg::cell_view_t views [N];
  tcp_ecf_pkg::cell_view_t vsel;

  assign hit_c[0]  = 1'b0;
  assign free_c[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tcp_ecf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .seg      (seg_r),
      .hit_in   (hit_c[g]),
      .free_in  (free_c[g]),
      .apply    (apply),
      .alloc_en (alloc_en),
      .hit_out  (hit_c[g+1]),
      .free_out (free_c[g+1]),
      .alloc_wr (alloc_wr[g]),
      .view     (views[g])
    );
    assign hit_v[g] = views[g].hit;
  end

  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign apply        = state_r == S_LOOK;

  always_comb begin
    vsel = '0;
    for (int i = 0; i < N; i++) vsel = vsel | views[i];
  end

  always_comb begin
    alloc_en = 1'b0;
    cnt_nxt  = 2'd0;
    res0_nxt = '0;
    res1_nxt = '0;
    res0_nxt.window_out      = rwin_r;
    res0_nxt.local_port_out  = seg_r.dst_port;
    res0_nxt.remote_port_out = seg_r.src_port;
    res0_nxt.remote_addr_out = seg_r.src_addr;
    if (!hit_c[N]) begin
      if (free_c[N] && (seg_r.flags_in & tcp_ecf_pkg::F_SYN) != 8'h00) begin
        cnt_nxt = 2'd1;
        if (seg_r.dst_port == echo_port_r) begin
          alloc_en           = 1'b1;
          res0_nxt.seg_flags = tcp_ecf_pkg::F_SYN | tcp_ecf_pkg::F_ACK;
          res0_nxt.seq_out   = seg_r.time_now;
          res0_nxt.ack_out   = seg_r.seq_in + 32'd1;
        end else begin
          res0_nxt.seg_flags  = tcp_ecf_pkg::F_RST;
          res0_nxt.window_out = 16'd0;
        end
      end
    end else if (vsel.fin_go || vsel.psh_go) begin
      cnt_nxt            = 2'd2;
      res0_nxt.seg_flags = tcp_ecf_pkg::F_ACK;
      res0_nxt.seq_out   = vsel.snd;
      res0_nxt.ack_out   = vsel.rcv;
    end
    res1_nxt           = res0_nxt;
    res1_nxt.seg_flags = vsel.fin_go ? (tcp_ecf_pkg::F_FIN | tcp_ecf_pkg::F_ACK) :
                                       (tcp_ecf_pkg::F_PSH | tcp_ecf_pkg::F_ACK);
    res1_nxt.echo_len  = vsel.psh_go ? seg_r.payload_len : 11'd0;
    lastidx_nxt        = cnt_nxt == 2'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 1'b0;
      echo_port_r <= tcp_ecf_pkg::ECHO_PORT_RST;
      rwin_r      <= tcp_ecf_pkg::RWIN_RST;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          tcp_ecf_pkg::CFG_ECHO_PORT: echo_port_r <= cfg_ch.data;
          tcp_ecf_pkg::CFG_RWIN:      rwin_r      <= cfg_ch.data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) state_r <= S_LOOK;
        end
        S_LOOK: begin
          idx_r   <= 1'b0;
          state_r <= (cnt_nxt == 2'd0) ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (idx_r == lastidx_r) state_r <= S_IDLE;
            else idx_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      seg_r.src_addr    <= in_ch.src_addr;
      seg_r.src_port    <= in_ch.src_port;
      seg_r.dst_port    <= in_ch.dst_port;
      seg_r.seq_in      <= in_ch.seq_in;
      seg_r.ack_in      <= in_ch.ack_in;
      seg_r.flags_in    <= in_ch.flags_in;
      seg_r.payload_len <= (in_ch.payload_len > tcp_ecf_pkg::MAX_PAYLOAD) ?
                           tcp_ecf_pkg::MAX_PAYLOAD : in_ch.payload_len;
      seg_r.time_now    <= in_ch.time_now;
    end
    if (state_r == S_LOOK) begin
      res0_r    <= res0_nxt;
      res1_r    <= res1_nxt;
      lastidx_r <= lastidx_nxt;
    end
  end

  tcp_ecf_pkg::res_t res_cur;
  assign res_cur                = idx_r ? res1_r : res0_r;
  assign out_ch.valid           = state_r == S_OUT;
  assign out_ch.seg_flags       = res_cur.seg_flags;
  assign out_ch.seq_out         = res_cur.seq_out;
  assign out_ch.ack_out         = res_cur.ack_out;
  assign out_ch.window_out      = res_cur.window_out;
  assign out_ch.local_port_out  = res_cur.local_port_out;
  assign out_ch.remote_port_out = res_cur.remote_port_out;
  assign out_ch.remote_addr_out = res_cur.remote_addr_out;
  assign out_ch.echo_len        = res_cur.echo_len;
  assign out_ch.last            = idx_r == lastidx_r;

  // at most one cell claims the segment, at most one is allocated, none while an entry matches
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_v))
    else $error("more than one cell claims the segment");
  a_one_alloc: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(alloc_wr))
    else $error("more than one cell allocated");
  a_no_alloc_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
      hit_c[N] |-> alloc_wr == '0)
    else $error("allocation while an entry matches");
  a_look_once: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_LOOK |=> state_r != S_LOOK)
    else $error("lookup applied twice");

endmodule
